@@ design/turtle_move_to_wheel_steps_top_defines.svh @@
// ----------------------------------------------------------------------------
// Turtle wheel-step assertion macros
// Shared property forms for the turtle kinematics assertions.
// ----------------------------------------------------------------------------
`ifndef TURTLE_MOVE_TO_WHEEL_STEPS_TOP_DEFINES_SVH
`define TURTLE_MOVE_TO_WHEEL_STEPS_TOP_DEFINES_SVH

// same-cycle implication
`define TMWS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tmws assertion failed");

// next-cycle implication
`define TMWS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tmws assertion failed");

`endif

@@ design/tmws_pkg.sv @@
// ----------------------------------------------------------------------------
// Turtle wheel-step package
// Payload types, sequencer states, register indexes and the CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package tmws_pkg;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_FACE = 2'd1,
        OP_POSE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_STEPS_PER_UNIT = 2'd0,
        REG_TURN_CIRC      = 2'd1,
        REG_BACKLASH       = 2'd2,
        REG_MOVE_SCALE     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_NEG     = 2'd0,
        DIR_POS     = 2'd1,
        DIR_UNKNOWN = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CORDIC,
        ST_ROUND,
        ST_DEG,
        ST_TMUL1,
        ST_TMUL2,
        ST_TDIV,
        ST_TEMIT,
        ST_FSQ1,
        ST_FSQ2,
        ST_FMUL,
        ST_SQRT,
        ST_FSCALE,
        ST_FEMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic               pen_up;
        logic [15:0]        new_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_steps;
        logic signed [15:0] right_steps;
        logic               pen_down;
        logic               last;
    } out_item_t;

    localparam int unsigned FULL_TURN        = 46080;
    localparam int unsigned FULL_TURN_FINE   = 23592960;
    localparam int unsigned HALF_TURN_FINE   = 11796480;
    localparam int unsigned TURN_RECIP       = 5965233;
    localparam int unsigned TURN_RECIP_SHIFT = 28;
    localparam int unsigned SQRT_STEPS       = 26;

    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/turtle_move_to_wheel_steps_top.sv @@
// ----------------------------------------------------------------------------
// Turtle move to wheel steps
// Keeps the turtle pose and turns target points into turn and forward
// wheel step commands with backlash compensation.
// ----------------------------------------------------------------------------
// Flow: the CORDIC iterations find the bearing and a turn command follows when
//   the heading changes; a move then takes the 26-step square root for its
//   forward command. A new transaction is taken only when idle, after the last
//   one has finished; output stalls hold the sequencer in its emit states.
// Reset: pose zero, wheel directions unknown, registers to defaults.
`default_nettype none
`include "turtle_move_to_wheel_steps_top_defines.svh"

module turtle_move_to_wheel_steps_top
    import tmws_pkg::*;
#(
    parameter int CORDIC_ITERS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CW = 29;
    localparam int ZW = 26;

    state_t st_reg, st_next;

    logic [15:0] spu_reg, tc_reg;
    logic [7:0]  bl_reg, ms_reg;
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [15:0] heading_reg;
    logic [1:0]  dir_reg [2];

    in_item_t    item_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] brg_reg;
    logic signed [9:0] deg_reg;
    logic [41:0] prod_reg;
    logic [15:0] msq_reg;
    logic [51:0] q_reg;
    logic [28:0] rem_reg;
    logic [25:0] root_reg;

    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        in_fire;
    logic        emit_en;
    logic        emit_fire;
    logic signed [35:0] emit_l, emit_r;
    logic        emit_pen, emit_last;

    logic signed [16:0] dx, dy, north;
    logic        same_pos;
    logic signed [CW-1:0] ysh, xsh;
    logic [4:0]  last_iter;

    logic [28:0] rem_sh, trial;
    logic signed [16:0] hdiff;
    logic [16:0] hmag;
    logic signed [9:0]  deg_raw;
    logic [8:0]  deg_mag;
    logic [ZW-1:0] zw;
    logic [16:0] zr;

    assign last_iter = 5'(CORDIC_ITERS - 1);
    assign in_fire   = in_valid && !in_stall;
    assign emit_fire = emit_en && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dx       = 17'(item_reg.target_x) - 17'(pos_x_reg);
    assign dy       = 17'(item_reg.target_y) - 17'(pos_y_reg);
    assign north    = 17'(pos_y_reg) - 17'(item_reg.target_y);
    assign same_pos = (item_reg.target_x == pos_x_reg) && (item_reg.target_y == pos_y_reg);
    assign ysh      = cy_reg >>> cnt_reg;
    assign xsh      = cx_reg >>> cnt_reg;

    assign rem_sh   = {rem_reg[26:0], q_reg[51:50]};
    assign trial    = {1'b0, root_reg, 2'b01};

    assign hdiff    = 17'(heading_reg) - 17'(brg_reg);
    assign hmag     = (hdiff < 0) ? 17'(-hdiff) : 17'(hdiff);
    assign deg_raw  = (hdiff < 0) ? -10'(hmag[16:7]) : 10'(hmag[16:7]);
    assign deg_mag  = (deg_reg < 0) ? 9'(-deg_reg) : 9'(deg_reg);

    assign zw       = (z_reg < 0) ? ZW'(z_reg + ZW'(FULL_TURN_FINE)) : ZW'(z_reg);
    assign zr       = 17'((zw + ZW'(256)) >> 9);

    function automatic logic [15:0] wheel_val(input logic signed [35:0] c,
                                              input logic [1:0] d,
                                              input logic [7:0] bl);
        logic signed [36:0] v;
        v = 37'(c);
        if (d == DIR_NEG && c > 0)
            v = v + 37'(bl);
        if (d == DIR_POS && c <= 0)
            v = v - 37'(bl);
        if (v > 37'sd32767)
            v = 37'sd32767;
        if (v < -37'sd32768)
            v = -37'sd32768;
        return v[15:0];
    endfunction

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:   if (in_fire) st_next = ST_INIT;
            ST_INIT:
            begin
                if (item_reg.operation == OP_POSE || item_reg.operation == OP_NONE || same_pos)
                    st_next = ST_IDLE;
                else
                    st_next = ST_CORDIC;
            end
            ST_CORDIC: if (cnt_reg == last_iter) st_next = ST_ROUND;
            ST_ROUND:  st_next = ST_DEG;
            ST_DEG:
            begin
                if (deg_raw != 0)
                    st_next = ST_TMUL1;
                else if (item_reg.operation == OP_MOVE)
                    st_next = ST_FSQ1;
                else
                    st_next = ST_DONE;
            end
            ST_TMUL1:  st_next = ST_TMUL2;
            ST_TMUL2:  st_next = ST_TDIV;
            ST_TDIV:   st_next = ST_TEMIT;
            ST_TEMIT:
            begin
                if (emit_fire)
                    st_next = (item_reg.operation == OP_MOVE) ? ST_FSQ1 : ST_DONE;
            end
            ST_FSQ1:   st_next = ST_FSQ2;
            ST_FSQ2:   st_next = ST_FMUL;
            ST_FMUL:   st_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 5'(SQRT_STEPS - 1)) st_next = ST_FSCALE;
            ST_FSCALE: st_next = ST_FEMIT;
            ST_FEMIT:  if (emit_fire) st_next = ST_DONE;
            ST_DONE:   st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (st_reg != ST_IDLE);
        emit_en   = 1'b0;
        emit_l    = '0;
        emit_r    = '0;
        emit_pen  = 1'b0;
        emit_last = 1'b0;
        case (st_reg)
            ST_TEMIT:
            begin
                emit_en   = 1'b1;
                emit_l    = (deg_reg < 0) ? -36'(q_reg[21:0]) : 36'(q_reg[21:0]);
                emit_r    = emit_l;
                emit_last = (item_reg.operation != OP_MOVE);
            end
            ST_FEMIT:
            begin
                emit_en   = 1'b1;
                emit_l    = -36'(prod_reg[41:8]);
                emit_r    = 36'(prod_reg[41:8]);
                emit_pen  = !item_reg.pen_up;
                emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            spu_reg       <= 16'd256;
            tc_reg        <= 16'd256;
            bl_reg        <= 8'd0;
            ms_reg        <= 8'd1;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            dir_reg[0]    <= DIR_UNKNOWN;
            dir_reg[1]    <= DIR_UNKNOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEPS_PER_UNIT: spu_reg <= cfg_data;
                    REG_TURN_CIRC:      tc_reg  <= cfg_data;
                    REG_BACKLASH:       bl_reg  <= cfg_data[7:0];
                    REG_MOVE_SCALE:     ms_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                dir_reg[0]    <= (emit_l > 0) ? DIR_POS : DIR_NEG;
                dir_reg[1]    <= (emit_r > 0) ? DIR_POS : DIR_NEG;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_reg == ST_INIT && item_reg.operation == OP_POSE)
            begin
                pos_x_reg   <= item_reg.target_x;
                pos_y_reg   <= item_reg.target_y;
                heading_reg <= (item_reg.new_heading >= 16'(FULL_TURN)) ?
                               item_reg.new_heading - 16'(FULL_TURN) : item_reg.new_heading;
            end
            if (st_reg == ST_DONE)
            begin
                heading_reg <= brg_reg;
                if (item_reg.operation == OP_MOVE)
                begin
                    pos_x_reg <= item_reg.target_x;
                    pos_y_reg <= item_reg.target_y;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
        if (emit_fire)
        begin
            out_data_reg.left_steps  <= wheel_val(emit_l, dir_reg[0], bl_reg);
            out_data_reg.right_steps <= wheel_val(emit_r, dir_reg[1], bl_reg);
            out_data_reg.pen_down    <= emit_pen;
            out_data_reg.last        <= emit_last;
        end
        case (st_reg)
            ST_INIT:
            begin
                cnt_reg <= '0;
                if (north < 0)
                begin
                    cx_reg <= -(CW'(north) <<< 8);
                    cy_reg <= -(CW'(dx) <<< 8);
                    z_reg  <= ZW'(HALF_TURN_FINE);
                end
                else
                begin
                    cx_reg <= CW'(north) <<< 8;
                    cy_reg <= CW'(dx) <<< 8;
                    z_reg  <= '0;
                end
            end
            ST_CORDIC:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ysh;
                    cy_reg <= cy_reg - xsh;
                    z_reg  <= z_reg + ZW'(atan_entry(cnt_reg));
                end
                else
                begin
                    cx_reg <= cx_reg - ysh;
                    cy_reg <= cy_reg + xsh;
                    z_reg  <= z_reg - ZW'(atan_entry(cnt_reg));
                end
            end
            ST_ROUND:
                brg_reg <= (zr >= 17'(FULL_TURN)) ? 16'd0 : zr[15:0];
            ST_DEG:
            begin
                if (deg_raw > 10'sd180)
                    deg_reg <= deg_raw - 10'sd360;
                else if (deg_raw < -10'sd180)
                    deg_reg <= deg_raw + 10'sd360;
                else
                    deg_reg <= deg_raw;
            end
            ST_TMUL1:
                prod_reg <= 42'(tc_reg * spu_reg);
            ST_TMUL2:
            begin
                q_reg   <= 52'((41'(prod_reg[31:0]) * 41'(deg_mag)) >> 19);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_TDIV:
                q_reg <= 52'((45'(q_reg[21:0]) * 45'(TURN_RECIP)) >> TURN_RECIP_SHIFT);
            ST_FSQ1:
            begin
                prod_reg <= 42'(34'(dx * dx));
                msq_reg  <= ms_reg * ms_reg;
            end
            ST_FSQ2:
                prod_reg <= prod_reg + 42'(34'(dy * dy));
            ST_FMUL:
            begin
                q_reg    <= 52'(prod_reg[34:0]) * 52'(msq_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                q_reg   <= {q_reg[49:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[24:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[24:0], 1'b0};
                end
            end
            ST_FSCALE:
                prod_reg <= 42'(root_reg) * 42'(spu_reg);
            default: ;
        endcase
    end

    `TMWS_ASSERT_NEXT(a_accept_busy, in_fire, in_stall)
    `TMWS_ASSERT_NEXT(a_more_follows, out_valid && !out_stall && !out_data.last, st_reg != ST_IDLE)
    `TMWS_ASSERT_NOW(a_sqrt_bound, st_reg == ST_SQRT, cnt_reg < 5'(SQRT_STEPS))

endmodule

`default_nettype wire
